@@ design/bdwm_pkg.sv @@
package bdwm_pkg;

   localparam int unsigned SAMPLE_W = 32;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned BDWM_HISTORY_DEPTH = 20;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hfffe;
   localparam logic [COUNT_W-1:0] MIN_SAMPLES_RESET = 16'd120;

   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_ADJUST = 1'b1;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [COUNT_W-1:0] count_type;

   // a is below b when b - a lies in 1 .. 2^31-1 (serial-number order)
   function automatic logic serial_below(sample_type a, sample_type b);
      sample_type diff;
      diff = b - a;
      return (diff[SAMPLE_W-1] == 1'b0) && (diff != '0);
   endfunction

endpackage

@@ design/bdwm_req_if.sv @@
interface bdwm_req_if
   import bdwm_pkg::*;
();
   logic valid;
   logic ready;
   logic command;
   logic [SAMPLE_W-1:0] sample;
   logic step;
   logic signed [SAMPLE_W-1:0] base_change;

   modport source (output valid, command, sample, step, base_change, input ready);
   modport sink (input valid, command, sample, step, base_change, output ready);
endinterface

@@ design/bdwm_rsp_if.sv @@
interface bdwm_rsp_if
   import bdwm_pkg::*;
();
   logic valid;
   logic ready;
   logic [SAMPLE_W-1:0] delay;

   modport source (output valid, delay, input ready);
   modport sink (input valid, delay, output ready);
endinterface

@@ design/bdwm_ram.sv @@
module bdwm_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/base_delay_window_min_tracker.sv @@
// add transaction: accepted in idle, then updated in exec, which stalls while a held result waits
// first add sample: a fill state first writes it to every history slot
// add with an honored step: step write, scan, drain; adjust: base adjust, scan, drain; the scan
// reads one history ram entry per cycle; one transaction at a time
// synchronous active-high reset clears base, count, slot and started, reloads the threshold
// (120); history ram is not cleared, the first sample fills it
module base_delay_window_min_tracker
   import bdwm_pkg::*;
#(
   parameter int unsigned HISTORY_DEPTH = BDWM_HISTORY_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   bdwm_req_if.sink           req_chan,
   bdwm_rsp_if.source         rsp_chan,
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_EXEC,
      ST_STEP_WR,
      ST_ADJ_BASE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type  state_ff, state_in;
   sample_type sample_ff, sample_in;
   logic       step_ff, step_in;
   sample_type change_ff, change_in;
   sample_type base_ff, base_in;
   sample_type cur_ff, cur_in;
   count_type  count_ff, count_in;
   count_type  thresh_ff, thresh_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] didx_ff, didx_in;
   logic       dvld_ff, dvld_in;
   logic       adj_mode_ff, adj_mode_in;
   logic       started_ff, started_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_delay_ff, rsp_delay_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   sample_type       wr_data;
   logic             rd_en;
   sample_type       rd_data;

   count_type  count_inc;
   sample_type base_new;
   logic       step_taken;

   bdwm_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.delay = rsp_delay_ff;

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      step_in      = step_ff;
      change_in    = change_ff;
      base_in      = base_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      thresh_in    = csr_wr_en ? csr_wr_data : thresh_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      didx_in      = idx_ff;
      dvld_in      = 1'b0;
      adj_mode_in  = adj_mode_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_delay_in = rsp_delay_ff;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = sample_ff;
      rd_en        = 1'b0;
      count_inc    = (count_ff < COUNT_LIMIT) ? count_ff + 1'b1 : count_ff;
      base_new     = base_ff;
      step_taken   = 1'b0;

      // scan data arrives in the cycle after its read
      if (dvld_ff && serial_below(rd_data, base_ff)) begin
         if (adj_mode_ff) begin
            wr_en   = 1'b1;
            wr_addr = didx_ff;
            wr_data = base_ff;
            if (didx_ff == slot_ff) begin
               cur_in = base_ff;
            end
         end else begin
            base_in = rd_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sample_in = req_chan.sample;
               step_in   = req_chan.step;
               change_in = sample_type'(req_chan.base_change);
               if (req_chan.command == CMD_ADJUST) begin
                  if (started_ff) begin
                     state_in = ST_ADJ_BASE;
                  end
               end else if (!started_ff) begin
                  base_in    = req_chan.sample;
                  cur_in     = req_chan.sample;
                  count_in   = '0;
                  started_in = 1'b1;
                  idx_in     = '0;
                  state_in   = ST_FILL;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = sample_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_EXEC;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               if (serial_below(sample_ff, base_ff)) begin
                  base_new = sample_ff;
                  wr_en    = 1'b1;
                  cur_in   = sample_ff;
               end else if (serial_below(sample_ff, cur_ff)) begin
                  wr_en  = 1'b1;
                  cur_in = sample_ff;
               end
               base_in      = base_new;
               rsp_valid_in = 1'b1;
               rsp_delay_in = sample_ff - base_new;
               step_taken   = step_ff && (count_inc > thresh_ff);
               if (step_taken) begin
                  count_in = '0;
                  slot_in  = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
                  base_in  = sample_ff;
                  cur_in   = sample_ff;
                  state_in = ST_STEP_WR;
               end else begin
                  count_in = count_inc;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STEP_WR: begin
            wr_en       = 1'b1;
            wr_addr     = slot_ff;
            wr_data     = sample_ff;
            idx_in      = '0;
            adj_mode_in = 1'b0;
            state_in    = ST_SCAN;
         end
         ST_ADJ_BASE: begin
            base_in     = base_ff + change_ff;
            idx_in      = '0;
            adj_mode_in = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            dvld_in = 1'b1;
            didx_in = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         count_ff     <= '0;
         thresh_ff    <= MIN_SAMPLES_RESET;
         slot_ff      <= '0;
         idx_ff       <= '0;
         dvld_ff      <= 1'b0;
         adj_mode_ff  <= 1'b0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         thresh_ff    <= thresh_in;
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         dvld_ff      <= dvld_in;
         adj_mode_ff  <= adj_mode_in;
         started_ff   <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      step_ff      <= step_in;
      change_ff    <= change_in;
      cur_ff       <= cur_in;
      didx_ff      <= didx_in;
      rsp_delay_ff <= rsp_delay_in;
   end

endmodule
